// ----- src/tunc_pkg.sv -----
// Shared types and constants for the triangle unit normal core.
// Used by tunc_root_step and triangle_unit_normal_camera_facing_core.
package tunc_pkg;

  // Field widths
  localparam int unsigned CoordW = 24;  // Q12.12 vertex / camera coordinate
  localparam int unsigned NrmW   = 16;  // Q1.14 normal component
  localparam int unsigned DiffW  = 25;  // edge vector component
  localparam int unsigned SumW   = 26;  // vertex sum
  localparam int unsigned DirW   = 27;  // 3*camera - vertex sum
  localparam int unsigned ProdW  = 50;  // edge product
  localparam int unsigned CrossW = 51;  // signed cross component
  localparam int unsigned MagW   = 50;  // cross magnitude
  localparam int unsigned HalfW  = 25;  // half of a magnitude for squaring
  localparam int unsigned DotPW  = 53;  // dot partial product
  localparam int unsigned DotW   = 80;  // full dot product
  localparam int unsigned SqW    = 100; // squared cross component
  localparam int unsigned SumSqW = 102; // squared length of cross product
  localparam int unsigned RhsW   = 130; // squared component scaled by 2^30
  localparam int unsigned WideW  = 137; // search accumulators
  localparam int unsigned RootW  = 15;  // unsigned normal magnitude, 0..16384
  localparam int unsigned RootSteps = 15;

  localparam int unsigned RhsShift = 30;
  localparam logic [NrmW-1:0] OneQ14 = 16'd16384;

  // Centroid divide by three: floor(x * ceil(2^27/3) / 2^27) is exact for x < 2^25
  localparam int unsigned CenShift = 27;
  localparam logic [25:0] CenRecip = 26'd44739243;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  typedef enum logic [CfgIdxW-1:0] {
    CfgFlip    = 8'd0,
    CfgCameraX = 8'd1,
    CfgCameraY = 8'd2,
    CfgCameraZ = 8'd3
  } cfg_idx_e;

  // Per-component state of the bit-by-bit normalization search
  typedef struct packed {
    logic signed [WideW-1:0] f;  // (u-1)^2 * S for the current estimate
    logic signed [WideW-1:0] g;  // (u-1) * S
    logic [RhsW-1:0]         r;  // 2^30 * n^2
    logic [RootW-1:0]        m;  // magnitude found so far
  } root_t;

  // Side data traveling beside the search
  typedef struct packed {
    logic signed [CoordW-1:0] cen_x;
    logic signed [CoordW-1:0] cen_y;
    logic signed [CoordW-1:0] cen_z;
    logic [2:0]               neg;    // final sign per normal component
    logic                     degen;
  } side_t;

endpackage

// ----- src/tunc_root_step.sv -----
// One pipeline stage of the normalization search: decides one magnitude bit
// for all three components. Depends on tunc_pkg.
module tunc_root_step
  import tunc_pkg::*;
#(
  parameter int unsigned Bit = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  side_t             side_i,
  input  logic [SumSqW-1:0] s_i,
  input  root_t [2:0]       root_i,
  output logic              valid_o,
  output side_t             side_o,
  output logic [SumSqW-1:0] s_o,
  output root_t [2:0]       root_o
);

  logic signed [WideW-1:0] s_ext;
  root_t [2:0]             root_d;
  logic                    valid_q;
  side_t                   side_q;
  logic [SumSqW-1:0]       s_q;
  root_t [2:0]             root_q;

  assign s_ext = $signed(WideW'(s_i));

  // Trial: u grows by 2^(Bit+1); keep it if (u-1)^2*S stays within 2^30*n^2
  always_comb begin
    logic signed [WideW-1:0] fc;
    for (int c = 0; c < 3; c++) begin
      fc = root_i[c].f + (root_i[c].g <<< (Bit + 2)) + (s_ext <<< (2 * Bit + 2));
      root_d[c] = root_i[c];
      if (fc <= $signed(WideW'(root_i[c].r))) begin
        root_d[c].f = fc;
        root_d[c].g = root_i[c].g + (s_ext <<< (Bit + 1));
        root_d[c].m = root_i[c].m | (RootW'(1) << Bit);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    s_q    <= s_i;
    root_q <= root_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign s_o     = s_q;
  assign root_o  = root_q;

endmodule

// ----- src/triangle_unit_normal_camera_facing_core.sv -----
// Triangle unit normal core: centroid, Q1.14 unit face normal, camera flip.
// Throughput: one item per cycle; busy is always low (6 arithmetic stages,
// 15 normalization stages of one bit each, one output stage).
// Reset clears the valid bits and the configuration registers; the receiver
// cannot stall, so each result is shown for exactly one cycle.
// Depends on tunc_pkg and tunc_root_step.
module triangle_unit_normal_camera_facing_core
  import tunc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // item channel
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] ax_i,
  input  logic signed [CoordW-1:0] ay_i,
  input  logic signed [CoordW-1:0] az_i,
  input  logic signed [CoordW-1:0] bx_i,
  input  logic signed [CoordW-1:0] by_i,
  input  logic signed [CoordW-1:0] bz_i,
  input  logic signed [CoordW-1:0] cx_i,
  input  logic signed [CoordW-1:0] cy_i,
  input  logic signed [CoordW-1:0] cz_i,
  // configuration channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CoordW-1:0]        cfg_data_i,
  // result channel
  output logic                     out_valid_o,
  output logic signed [NrmW-1:0]   normal_x_o,
  output logic signed [NrmW-1:0]   normal_y_o,
  output logic signed [NrmW-1:0]   normal_z_o,
  output logic signed [CoordW-1:0] centroid_x_o,
  output logic signed [CoordW-1:0] centroid_y_o,
  output logic signed [CoordW-1:0] centroid_z_o,
  output logic                     degenerate_o
);

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  logic                     flip_q;
  logic signed [CoordW-1:0] cam_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_q <= 1'b0;
      cam_q[0] <= '0;
      cam_q[1] <= '0;
      cam_q[2] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFlip:    flip_q   <= cfg_data_i[0];
        CfgCameraX: cam_q[0] <= cfg_data_i;
        CfgCameraY: cam_q[1] <= cfg_data_i;
        CfgCameraZ: cam_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits of the arithmetic stages
  logic [5:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], start & ~busy};
    end
  end

  // Stage 1: edge vectors and vertex sums
  logic signed [DiffW-1:0] u1_q [3];
  logic signed [DiffW-1:0] w1_q [3];
  logic signed [SumW-1:0]  sum1_q [3];
  logic                    flip1_q;

  always_ff @(posedge clk_i) begin
    u1_q[0]   <= DiffW'(bx_i) - DiffW'(ax_i);
    u1_q[1]   <= DiffW'(by_i) - DiffW'(ay_i);
    u1_q[2]   <= DiffW'(bz_i) - DiffW'(az_i);
    w1_q[0]   <= DiffW'(cx_i) - DiffW'(ax_i);
    w1_q[1]   <= DiffW'(cy_i) - DiffW'(ay_i);
    w1_q[2]   <= DiffW'(cz_i) - DiffW'(az_i);
    sum1_q[0] <= SumW'(ax_i) + SumW'(bx_i) + SumW'(cx_i);
    sum1_q[1] <= SumW'(ay_i) + SumW'(by_i) + SumW'(cy_i);
    sum1_q[2] <= SumW'(az_i) + SumW'(bz_i) + SumW'(cz_i);
    flip1_q   <= flip_q;
  end

  // Stage 2: edge products, centroid reciprocal multiply, view vector
  logic signed [ProdW-1:0] pa2_q [3];
  logic signed [ProdW-1:0] pb2_q [3];
  logic [CoordW-1:0]       cenm2_q [3];
  logic [2:0]              cens2_q;
  logic signed [DirW-1:0]  d2_q [3];
  logic                    flip2_q;

  always_ff @(posedge clk_i) begin
    logic [SumW-1:0]    smag;
    logic [2*SumW-2:0]  cprod;
    pa2_q[0] <= ProdW'(u1_q[1]) * ProdW'(w1_q[2]);
    pb2_q[0] <= ProdW'(u1_q[2]) * ProdW'(w1_q[1]);
    pa2_q[1] <= ProdW'(u1_q[2]) * ProdW'(w1_q[0]);
    pb2_q[1] <= ProdW'(u1_q[0]) * ProdW'(w1_q[2]);
    pa2_q[2] <= ProdW'(u1_q[0]) * ProdW'(w1_q[1]);
    pb2_q[2] <= ProdW'(u1_q[1]) * ProdW'(w1_q[0]);
    for (int i = 0; i < 3; i++) begin
      smag = sum1_q[i][SumW-1] ? SumW'(-sum1_q[i]) : SumW'(sum1_q[i]);
      cprod = (2*SumW-1)'(smag[SumW-2:0]) * (2*SumW-1)'(CenRecip);
      cenm2_q[i] <= cprod[CenShift+CoordW-1:CenShift];
      cens2_q[i] <= sum1_q[i][SumW-1];
      d2_q[i] <= DirW'(cam_q[i]) + (DirW'(cam_q[i]) <<< 1) - DirW'(sum1_q[i]);
    end
    flip2_q <= flip1_q;
  end

  // Stage 3: cross product, magnitudes, degenerate flag
  logic signed [CrossW-1:0] crd3_q [3];
  logic [MagW-1:0]          mag3_q [3];
  logic [2:0]               neg3_q;
  logic                     degen3_q;
  logic signed [DirW-1:0]   d3_q [3];
  logic signed [CoordW-1:0] cen3_q [3];
  logic                     flip3_q;

  always_ff @(posedge clk_i) begin
    logic signed [CrossW-1:0] cr;
    logic signed [CrossW-1:0] crn;
    logic                     dg;
    dg = (pa2_q[0] == pb2_q[0]) && (pa2_q[1] == pb2_q[1]) && (pa2_q[2] == pb2_q[2]);
    for (int i = 0; i < 3; i++) begin
      cr  = CrossW'(pa2_q[i]) - CrossW'(pb2_q[i]);
      crn = CrossW'(pb2_q[i]) - CrossW'(pa2_q[i]);
      mag3_q[i] <= cr[CrossW-1] ? crn[MagW-1:0] : cr[MagW-1:0];
      neg3_q[i] <= cr[CrossW-1];
      // a degenerate triangle faces along +z for the facing test
      crd3_q[i] <= (i == 2) ? {cr[CrossW-1:1], cr[0] | dg} : cr;
      d3_q[i]   <= d2_q[i];
      cen3_q[i] <= cens2_q[i] ? -$signed(cenm2_q[i]) : $signed(cenm2_q[i]);
    end
    degen3_q <= dg;
    flip3_q  <= flip2_q;
  end

  // Stage 4: partial products of squares and of the facing dot product
  logic [2*HalfW-1:0]       hh4_q [3];
  logic [2*HalfW-1:0]       hl4_q [3];
  logic [2*HalfW-1:0]       ll4_q [3];
  logic signed [DotPW-1:0]  dh4_q [3];
  logic signed [DotPW-1:0]  dl4_q [3];
  logic [2:0]               neg4_q;
  logic                     degen4_q;
  logic signed [CoordW-1:0] cen4_q [3];
  logic                     flip4_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      hh4_q[i] <= (2*HalfW)'(mag3_q[i][MagW-1:HalfW]) * (2*HalfW)'(mag3_q[i][MagW-1:HalfW]);
      hl4_q[i] <= (2*HalfW)'(mag3_q[i][MagW-1:HalfW]) * (2*HalfW)'(mag3_q[i][HalfW-1:0]);
      ll4_q[i] <= (2*HalfW)'(mag3_q[i][HalfW-1:0]) * (2*HalfW)'(mag3_q[i][HalfW-1:0]);
      dh4_q[i] <= DotPW'($signed(crd3_q[i][CrossW-1:HalfW])) * DotPW'(d3_q[i]);
      dl4_q[i] <= DotPW'($signed({1'b0, crd3_q[i][HalfW-1:0]})) * DotPW'(d3_q[i]);
      cen4_q[i] <= cen3_q[i];
    end
    neg4_q   <= neg3_q;
    degen4_q <= degen3_q;
    flip4_q  <= flip3_q;
  end

  // Stage 5: squared components and the exact dot product
  logic [SqW-1:0]           n25_q [3];
  logic signed [DotW-1:0]   dot5_q;
  logic [2:0]               neg5_q;
  logic                     degen5_q;
  logic signed [CoordW-1:0] cen5_q [3];
  logic                     flip5_q;

  always_ff @(posedge clk_i) begin
    logic signed [DotW-1:0] acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      n25_q[i] <= (SqW'(hh4_q[i]) << (2*HalfW)) + (SqW'(hl4_q[i]) << (HalfW + 1))
                + SqW'(ll4_q[i]);
      acc = acc + (DotW'(dh4_q[i]) <<< HalfW) + DotW'(dl4_q[i]);
      cen5_q[i] <= cen4_q[i];
    end
    dot5_q   <= acc;
    neg5_q   <= neg4_q;
    degen5_q <= degen4_q;
    flip5_q  <= flip4_q;
  end

  // Stage 6: squared length, search setup, final signs
  logic                     v6_q;
  side_t                    side6_q;
  logic [SumSqW-1:0]        s6_q;
  root_t [2:0]              root6_q;

  assign v6_q = vld_q[5];

  always_ff @(posedge clk_i) begin
    logic [SumSqW-1:0] ss;
    logic              fl;
    ss = SumSqW'(n25_q[0]) + SumSqW'(n25_q[1]) + SumSqW'(n25_q[2]);
    fl = flip5_q & dot5_q[DotW-1];
    s6_q <= ss;
    for (int i = 0; i < 3; i++) begin
      root6_q[i].f <= $signed(WideW'(ss));
      root6_q[i].g <= -$signed(WideW'(ss));
      root6_q[i].r <= RhsW'(n25_q[i]) << RhsShift;
      root6_q[i].m <= '0;
      side6_q.neg[i] <= neg5_q[i] ^ fl;
    end
    side6_q.cen_x <= cen5_q[0];
    side6_q.cen_y <= cen5_q[1];
    side6_q.cen_z <= cen5_q[2];
    side6_q.degen <= degen5_q;
  end

  // Normalization search, most significant bit first
  logic              vc    [RootSteps+1];
  side_t             sc    [RootSteps+1];
  logic [SumSqW-1:0] ssc   [RootSteps+1];
  root_t [2:0]       rc    [RootSteps+1];

  assign vc[0]  = v6_q;
  assign sc[0]  = side6_q;
  assign ssc[0] = s6_q;
  assign rc[0]  = root6_q;

  for (genvar j = 0; j < RootSteps; j++) begin : g_root
    tunc_root_step #(
      .Bit(RootSteps - 1 - j)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vc[j]),
      .side_i  (sc[j]),
      .s_i     (ssc[j]),
      .root_i  (rc[j]),
      .valid_o (vc[j+1]),
      .side_o  (sc[j+1]),
      .s_o     (ssc[j+1]),
      .root_o  (rc[j+1])
    );
  end

  // Output stage: degenerate override and signs
  logic                     out_valid_q;
  logic signed [NrmW-1:0]   nrm_q [3];
  logic signed [CoordW-1:0] cen_q [3];
  logic                     degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= vc[RootSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [NrmW-1:0] nm;
    for (int i = 0; i < 3; i++) begin
      if (sc[RootSteps].degen) begin
        nm = (i == 2) ? OneQ14 : '0;
      end else begin
        nm = NrmW'(rc[RootSteps][i].m);
      end
      nrm_q[i] <= sc[RootSteps].neg[i] ? -$signed(nm) : $signed(nm);
    end
    cen_q[0] <= sc[RootSteps].cen_x;
    cen_q[1] <= sc[RootSteps].cen_y;
    cen_q[2] <= sc[RootSteps].cen_z;
    degen_q  <= sc[RootSteps].degen;
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = nrm_q[0];
  assign normal_y_o   = nrm_q[1];
  assign normal_z_o   = nrm_q[2];
  assign centroid_x_o = cen_q[0];
  assign centroid_y_o = cen_q[1];
  assign centroid_z_o = cen_q[2];
  assign degenerate_o = degen_q;

endmodule
